// ===== sv/swc_pkg.sv =====
package swc_pkg;

	// Field widths of the item and result payloads.
	localparam int PIX_W      = 16;
	localparam int WGT_W      = 16;
	localparam int WIDX_W     = 6;
	localparam int RES_W      = 37;
	localparam int POS_W      = 10;
	localparam int PROD_W     = PIX_W + WGT_W;

	// Configuration register widths and port widths.
	localparam int FW_W       = 11;
	localparam int FH_W       = 11;
	localparam int KS_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Default sizing of the storage.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_KERNEL = 7;

	// Largest number of output rows in a frame.
	localparam int ROW_LIMIT = 1024;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd2;

	// Register values after reset.
	localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
	localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
	localparam logic [KS_W-1:0] RST_KERNEL_SIZE  = 3'd3;

	// Item kinds.
	localparam logic KIND_WEIGHT = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	// One input item.
	typedef struct packed {
		logic                    kind;
		logic [WIDX_W-1:0]       weight_index;
		logic signed [WGT_W-1:0] weight_value;
		logic signed [PIX_W-1:0] pixel;
	} swc_in_t;

	// One result item.
	typedef struct packed {
		logic signed [RES_W-1:0] result;
		logic [POS_W-1:0]        out_row;
		logic [POS_W-1:0]        out_column;
		logic                    last;
	} swc_out_t;

	// Raw configuration register contents.
	typedef struct packed {
		logic [FW_W-1:0] frame_width;
		logic [FH_W-1:0] frame_height;
		logic [KS_W-1:0] kernel_size;
	} swc_cfg_t;

	// Position data that travels with an item down the pipeline.
	typedef struct packed {
		logic             produce;
		logic             last;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_column;
	} swc_meta_t;

	// Kernel weight write, issued in item order.
	typedef struct packed {
		logic                    en;
		logic [WIDX_W-1:0]       index;
		logic signed [WGT_W-1:0] value;
	} swc_wreq_t;

	// Stage loads for the front end.
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic restart;
	} swc_fe_ctrl_t;

	// Stage loads for the multiply and sum stages.
	typedef struct packed {
		logic load_s3;
		logic load_s4;
	} swc_mac_ctrl_t;

	// Clamp a register value into a range.
	function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
		int unsigned r;
		r = v;
		if (v < lo) r = lo;
		if (v > hi) r = hi;
		return r;
	endfunction

endpackage

// ===== sv/swc_ram.sv =====
module swc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1031
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/swc_frontend.sv =====
module swc_frontend #(
	parameter int MAX_WIDTH  = swc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = swc_pkg::DEF_MAX_KERNEL
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  swc_pkg::swc_cfg_t                cfg,
	input  swc_pkg::swc_fe_ctrl_t            ctrl,
	input  swc_pkg::swc_in_t                 item,
	output swc_pkg::swc_meta_t               meta_s2,
	output swc_pkg::swc_wreq_t               wreq,
	output logic signed [swc_pkg::PIX_W-1:0] window [MAX_KERNEL][MAX_KERNEL]
);

	import swc_pkg::*;

	localparam int STORE_COLS = MAX_WIDTH + MAX_KERNEL;
	localparam int COL_W      = $clog2(STORE_COLS);
	localparam int DIM_W      = COL_W + 1;
	localparam int ROW_W      = $clog2(ROW_LIMIT + MAX_KERNEL);
	localparam int RDIM_W     = ROW_W + 1;
	localparam int K_W        = $clog2(MAX_KERNEL + 1);
	localparam int SLOT_W     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_KERNEL - 1);

	logic [K_W-1:0]    k;
	logic [K_W-1:0]    pad;
	logic [DIM_W-1:0]  w;
	logic [DIM_W-1:0]  pw;
	logic [RDIM_W-1:0] h;
	logic [RDIM_W-1:0] ph;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;

	logic [DIM_W-1:0]  c1;
	logic [DIM_W-1:0]  kc;
	logic [DIM_W-1:0]  oj;
	logic [RDIM_W-1:0] r1;
	logic [RDIM_W-1:0] kr;
	logic [RDIM_W-1:0] oi;
	logic              pos_produce;
	logic              pos_last;
	logic              pixel_in;

	swc_in_t           item_s1;
	swc_meta_t         meta_s1;
	logic [SLOT_W-1:0] slot_s1;

	logic [PIX_W-1:0]        rd [MAX_KERNEL];
	logic signed [PIX_W-1:0] newcol [MAX_KERNEL];
	logic signed [PIX_W-1:0] win_q [MAX_KERNEL][MAX_KERNEL];

	// Frame geometry from the clamped registers.
	always_comb begin
		k   = K_W'(clamp_u(32'(cfg.kernel_size), 1, MAX_KERNEL));
		pad = k >> 1;
		w   = DIM_W'(clamp_u(32'(cfg.frame_width), 1, MAX_WIDTH));
		h   = RDIM_W'(clamp_u(32'(cfg.frame_height), 1, ROW_LIMIT));
		pw  = w + (DIM_W'(pad) << 1);
		ph  = h + (RDIM_W'(pad) << 1);
	end

	// Output position of the window that the incoming pixel completes.
	always_comb begin
		c1 = DIM_W'(col_q) + DIM_W'(1);
		r1 = RDIM_W'(row_q) + RDIM_W'(1);
		kc = DIM_W'(k);
		kr = RDIM_W'(k);
		oi = r1 - kr;
		oj = c1 - kc;
		pos_produce = (r1 >= kr) && (c1 >= kc) && (oi < h) && (oj < w);
		pos_last    = (oi == h - RDIM_W'(1)) && (oj == w - DIM_W'(1));
	end

	assign pixel_in = ctrl.load_s1 && (item.kind == KIND_PIXEL);

	// Padded-frame position counters; the row slot follows the row modulo the number of line RAMs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (ctrl.restart) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (pixel_in) begin
			if (c1 >= pw) begin
				col_q <= '0;
				if (r1 >= ph) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= ROW_W'(r1);
					slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
				end
			end else begin
				col_q <= COL_W'(c1);
			end
		end
	end

	// First stage: the accepted item, its position and its row slot.
	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			item_s1            <= item;
			meta_s1.produce    <= (item.kind == KIND_PIXEL) && pos_produce;
			meta_s1.last       <= pos_last;
			meta_s1.out_row    <= POS_W'(oi);
			meta_s1.out_column <= POS_W'(oj);
			slot_s1            <= slot_q;
		end
	end

	// One line RAM per row slot; all are read at the pixel's column.
	for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_line
		swc_ram #(
			.WIDTH(PIX_W),
			.DEPTH(STORE_COLS)
		) u_ram (
			.clk  (clk),
			.we   (pixel_in && (slot_q == SLOT_W'(g))),
			.waddr(col_q),
			.wdata(item.pixel),
			.re   (pixel_in),
			.raddr(col_q),
			.rdata(rd[g])
		);
	end

	// New window column: older rows from the line RAMs, the current row from the pixel.
	always_comb begin
		int s;
		s = 0;
		for (int t = 0; t < MAX_KERNEL; t++) begin
			if (t == MAX_KERNEL - 1) begin
				newcol[t] = item_s1.pixel;
			end else begin
				s = int'(slot_s1) - (MAX_KERNEL - 1 - t);
				if (s < 0) begin
					s = s + MAX_KERNEL;
				end
				newcol[t] = signed'(rd[SLOT_W'(s)]);
			end
		end
	end

	// The window shifts one column left for every pixel.
	always_ff @(posedge clk) begin
		if (ctrl.load_s2 && (item_s1.kind == KIND_PIXEL)) begin
			for (int t = 0; t < MAX_KERNEL; t++) begin
				for (int u = 0; u < MAX_KERNEL; u++) begin
					if (u == MAX_KERNEL - 1) begin
						win_q[t][u] <= newcol[t];
					end else begin
						win_q[t][u] <= win_q[t][u + 1];
					end
				end
			end
		end
	end

	// Second stage position data.
	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			meta_s2 <= meta_s1;
		end
	end

	// Weight items take effect as they leave the first stage, in item order.
	assign wreq.en    = ctrl.load_s2 && (item_s1.kind == KIND_WEIGHT);
	assign wreq.index = item_s1.weight_index;
	assign wreq.value = item_s1.weight_value;

	assign window = win_q;

endmodule

// ===== sv/swc_mac.sv =====
module swc_mac #(
	parameter int MAX_KERNEL = swc_pkg::DEF_MAX_KERNEL
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [swc_pkg::KS_W-1:0]         kernel_size,
	input  swc_pkg::swc_mac_ctrl_t           ctrl,
	input  swc_pkg::swc_wreq_t               wreq,
	input  swc_pkg::swc_meta_t               meta_s2,
	input  logic signed [swc_pkg::PIX_W-1:0] window [MAX_KERNEL][MAX_KERNEL],
	output swc_pkg::swc_meta_t               meta_s4,
	output logic signed [swc_pkg::RES_W-1:0] result
);

	import swc_pkg::*;

	localparam int WEIGHT_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int WI_W         = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
	localparam int K_W          = $clog2(MAX_KERNEL + 1);
	localparam int LOG_K        = $clog2(MAX_KERNEL);
	localparam int ROWS_W       = PROD_W + LOG_K;
	localparam int TOT_W        = ROWS_W + LOG_K;

	logic signed [WGT_W-1:0]  weights_q [WEIGHT_DEPTH];
	logic [K_W-1:0]           k;
	logic signed [WGT_W-1:0]  plane [MAX_KERNEL][MAX_KERNEL];
	logic                     region [MAX_KERNEL][MAX_KERNEL];
	logic signed [PROD_W-1:0] mult [MAX_KERNEL][MAX_KERNEL];
	logic signed [PROD_W-1:0] prod_s3 [MAX_KERNEL][MAX_KERNEL];
	swc_meta_t                meta_s3;
	logic signed [ROWS_W-1:0] rowsum [MAX_KERNEL];
	logic signed [ROWS_W-1:0] rows_s4 [MAX_KERNEL];
	logic signed [TOT_W-1:0]  total;

	assign k = K_W'(clamp_u(32'(kernel_size), 1, MAX_KERNEL));

	// Kernel weight store; indexes past the store are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WEIGHT_DEPTH; i++) begin
				weights_q[i] <= '0;
			end
		end else if (wreq.en && (int'(wreq.index) < WEIGHT_DEPTH)) begin
			weights_q[WI_W'(wreq.index)] <= wreq.value;
		end
	end

	// Map row-major kernel weights onto the bottom-right KxK corner of the window.
	always_comb begin
		for (int t = 0; t < MAX_KERNEL; t++) begin
			for (int u = 0; u < MAX_KERNEL; u++) begin
				region[t][u] = (t >= MAX_KERNEL - int'(k)) && (u >= MAX_KERNEL - int'(k));
				plane[t][u]  = '0;
				for (int kk = 1; kk <= MAX_KERNEL; kk++) begin
					if ((int'(k) == kk) && (t >= MAX_KERNEL - kk) && (u >= MAX_KERNEL - kk)) begin
						plane[t][u] = weights_q[WI_W'((t - (MAX_KERNEL - kk)) * kk
							+ (u - (MAX_KERNEL - kk)))];
					end
				end
			end
		end
	end

	// One multiplier per window position.
	always_comb begin
		for (int t = 0; t < MAX_KERNEL; t++) begin
			for (int u = 0; u < MAX_KERNEL; u++) begin
				mult[t][u] = plane[t][u] * window[t][u];
			end
		end
	end

	// Third stage: products, with positions outside the kernel forced to zero.
	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			meta_s3 <= meta_s2;
			for (int t = 0; t < MAX_KERNEL; t++) begin
				for (int u = 0; u < MAX_KERNEL; u++) begin
					prod_s3[t][u] <= region[t][u] ? mult[t][u] : '0;
				end
			end
		end
	end

	// Sum of each window row.
	always_comb begin
		for (int t = 0; t < MAX_KERNEL; t++) begin
			rowsum[t] = '0;
			for (int u = 0; u < MAX_KERNEL; u++) begin
				rowsum[t] = rowsum[t] + ROWS_W'(prod_s3[t][u]);
			end
		end
	end

	// Fourth stage: row sums.
	always_ff @(posedge clk) begin
		if (ctrl.load_s4) begin
			meta_s4 <= meta_s3;
			for (int t = 0; t < MAX_KERNEL; t++) begin
				rows_s4[t] <= rowsum[t];
			end
		end
	end

	// Final sum of the row sums, taken to the result width.
	always_comb begin
		total = '0;
		for (int t = 0; t < MAX_KERNEL; t++) begin
			total = total + TOT_W'(rows_s4[t]);
		end
	end

	assign result = RES_W'(total);

endmodule

// ===== sv/sliding_window_conv2d.sv =====
// A result passes the first, second, product and row-sum stages, then the result register.
// Throughput: one item per cycle while no stall holds the pipeline; each line RAM takes at most
// one pixel write and one column read a cycle. Weight items and pixels that complete no
// window give no result. Reset clears the position counters, stage valid bits and kernel
// weights and loads the register defaults; line RAMs and the window register hold no reset value.
module sliding_window_conv2d #(
	parameter int MAX_WIDTH  = swc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = swc_pkg::DEF_MAX_KERNEL
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  swc_pkg::swc_in_t                  item,
	output logic                              conv_valid,
	input  logic                              conv_stall,
	output swc_pkg::swc_out_t                 conv,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [swc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import swc_pkg::*;

	swc_cfg_t      cfg_q;
	logic          cfg_known;
	swc_fe_ctrl_t  fe_ctrl;
	swc_mac_ctrl_t mac_ctrl;
	swc_meta_t     meta_s2;
	swc_meta_t     meta_s4;
	swc_wreq_t     wreq;
	logic signed [RES_W-1:0] result;
	logic signed [PIX_W-1:0] window [MAX_KERNEL][MAX_KERNEL];

	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic v4_q;
	logic vo_q;
	swc_out_t conv_q;

	logic out_free;
	logic load_o;
	logic rdy4;
	logic rdy3;
	logic rdy2;
	logic rdy1;
	logic s2_leave;
	logic accept;

	// Configuration requests are always taken.
	assign cfg_ready = 1'b1;

	// A write to any known register restarts the frame.
	always_comb begin
		unique case (cfg_index) inside
			CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_KERNEL_SIZE: cfg_known = 1'b1;
			default: cfg_known = 1'b0;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= RST_FRAME_WIDTH;
			cfg_q.frame_height <= RST_FRAME_HEIGHT;
			cfg_q.kernel_size  <= RST_KERNEL_SIZE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  cfg_q.frame_width  <= FW_W'(cfg_data);
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= FH_W'(cfg_data);
				CFG_KERNEL_SIZE:  cfg_q.kernel_size  <= cfg_data[KS_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage advance: a stage loads when it is empty or its item moves on.
	// Items that give no result leave the pipeline after the second stage.
	always_comb begin
		out_free = !vo_q || !conv_stall;
		load_o   = v4_q && out_free;
		rdy4     = !v4_q || out_free;
		rdy3     = !v3_q || rdy4;
		s2_leave = v2_q && (!meta_s2.produce || rdy3);
		rdy2     = !v2_q || !meta_s2.produce || rdy3;
		rdy1     = !v1_q || rdy2;
		accept   = item_valid && rdy1;

		fe_ctrl.load_s1  = accept;
		fe_ctrl.load_s2  = v1_q && rdy2;
		fe_ctrl.restart  = cfg_valid && cfg_known;
		mac_ctrl.load_s3 = v2_q && meta_s2.produce && rdy3;
		mac_ctrl.load_s4 = v3_q && rdy4;
	end

	assign item_stall = !rdy1;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			v1_q <= accept || (v1_q && !fe_ctrl.load_s2);
			v2_q <= fe_ctrl.load_s2 || (v2_q && !s2_leave);
			v3_q <= mac_ctrl.load_s3 || (v3_q && !mac_ctrl.load_s4);
			v4_q <= mac_ctrl.load_s4 || (v4_q && !load_o);
			vo_q <= load_o || (vo_q && conv_stall);
		end
	end

	swc_frontend #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_KERNEL(MAX_KERNEL)
	) u_frontend (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctrl   (fe_ctrl),
		.item   (item),
		.meta_s2(meta_s2),
		.wreq   (wreq),
		.window (window)
	);

	swc_mac #(
		.MAX_KERNEL(MAX_KERNEL)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.kernel_size(cfg_q.kernel_size),
		.ctrl       (mac_ctrl),
		.wreq       (wreq),
		.meta_s2    (meta_s2),
		.window     (window),
		.meta_s4    (meta_s4),
		.result     (result)
	);

	// Result register; it holds while the downstream side stalls.
	always_ff @(posedge clk) begin
		if (load_o) begin
			conv_q.result     <= result;
			conv_q.out_row    <= meta_s4.out_row;
			conv_q.out_column <= meta_s4.out_column;
			conv_q.last       <= meta_s4.last;
		end
	end

	assign conv_valid = vo_q;
	assign conv       = conv_q;

endmodule
